// ===== hw/rtl/mse_pkg.sv =====
`timescale 1ns / 1ps

package mse_pkg;

  localparam int unsigned MEM_WORDS = 1024;
  localparam int unsigned MEM_AW    = $clog2(MEM_WORDS);
  localparam int unsigned REG_COUNT = 32;
  localparam int unsigned RF_AW     = $clog2(REG_COUNT);

  // clearing pass covers both the data memory and the register file
  localparam int unsigned CLR_WORDS = (MEM_WORDS > REG_COUNT) ? MEM_WORDS : REG_COUNT;
  localparam int unsigned CLR_AW    = $clog2(CLR_WORDS);

  localparam logic [CLR_AW:0]   CLR_MEM_END = (CLR_AW + 1)'(MEM_WORDS);
  localparam logic [CLR_AW-1:0] CLR_LAST    = CLR_AW'(CLR_WORDS - 1);
  localparam logic [29:0]       MEM_WORDS_W = 30'(MEM_WORDS);
  localparam logic [RF_AW-1:0]  DUMP_LAST   = RF_AW'(REG_COUNT - 1);

  // opcodes and function codes
  localparam logic [5:0] OP_SPECIAL = 6'd0;
  localparam logic [5:0] OP_LW      = 6'd35;
  localparam logic [5:0] OP_SW      = 6'd43;
  localparam logic [5:0] FN_ADD     = 6'd32;
  localparam logic [5:0] FN_SUB     = 6'd34;
  localparam logic [5:0] FN_SYSCALL = 6'd12;

  // syscall selectors in v0
  localparam logic [31:0] SYS_PRINT_INT  = 32'd1;
  localparam logic [31:0] SYS_PRINT_STR  = 32'd4;
  localparam logic [31:0] SYS_READ_INT   = 32'd5;
  localparam logic [31:0] SYS_EXIT       = 32'd10;
  localparam logic [31:0] SYS_PRINT_CHAR = 32'd11;

  localparam logic [RF_AW-1:0] REG_ZERO = RF_AW'(0);
  localparam logic [RF_AW-1:0] REG_V0   = RF_AW'(2);
  localparam logic [RF_AW-1:0] REG_A0   = RF_AW'(4);

  typedef enum logic [3:0] {
    EV_NONE        = 4'd0,
    EV_PRINT_INT   = 4'd1,
    EV_PRINT_STR   = 4'd2,
    EV_PRINT_CHAR  = 4'd3,
    EV_READ_TAKEN  = 4'd4,
    EV_EXIT        = 4'd5,
    EV_DUMP        = 4'd6,
    EV_BAD_INSTR   = 4'd7,
    EV_BAD_SYSCALL = 4'd8,
    EV_IGNORED     = 4'd9
  } event_e;

  typedef struct packed {
    event_e             event_res;
    logic signed [31:0] value;
    logic [4:0]         reg_index;
    logic [31:0]        instr_pc;
    logic               last;
  } res_t;

  // controller to datapath
  typedef struct packed {
    logic clear;
    logic capture;
    logic commit;
    logic mem_rd;
    logic load_done;
    logic dump_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_load;
    logic is_exit;
    logic clr_last;
    logic dump_last;
  } status_t;

endpackage

// ===== hw/rtl/mse_instr_if.sv =====
`timescale 1ns / 1ps

interface mse_instr_if;
  logic               valid;
  logic               ready;
  logic [31:0]        instr_word;
  logic signed [31:0] read_value;

  modport source (output valid, output instr_word, output read_value, input ready);
  modport sink (input valid, input instr_word, input read_value, output ready);
endinterface

// ===== hw/rtl/mse_res_if.sv =====
`timescale 1ns / 1ps

interface mse_res_if;
  logic               valid;
  logic               ready;
  logic [3:0]         event_res;
  logic signed [31:0] value;
  logic [4:0]         reg_index;
  logic [31:0]        instr_pc;
  logic               last;

  modport source (output valid, output event_res, output value, output reg_index,
                  output instr_pc, output last, input ready);
  modport sink (input valid, input event_res, input value, input reg_index,
                input instr_pc, input last, output ready);
endinterface

// ===== hw/rtl/mse_ram.sv =====
`timescale 1ns / 1ps

module mse_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/mse_ctrl.sv =====
`timescale 1ns / 1ps

module mse_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  input  mse_pkg::status_t status_i,
  output mse_pkg::cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_LOAD,
    ST_DUMP
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;
  logic   load_out;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (status_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (status_i.is_load) begin
          cmd_o.mem_rd = 1'b1;
          state_d      = ST_LOAD;
        end else if (out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = status_i.is_exit ? ST_DUMP : ST_IDLE;
        end
      end
      ST_LOAD: begin
        if (out_free) begin
          cmd_o.load_done = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      ST_DUMP: begin
        if (out_free) begin
          cmd_o.dump_out = 1'b1;
          if (status_i.dump_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign load_out = cmd_o.commit || cmd_o.load_done || cmd_o.dump_out;

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ===== hw/rtl/mse_datapath.sv =====
`timescale 1ns / 1ps

module mse_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mse_pkg::cmd_t      cmd_i,
  output mse_pkg::status_t   status_o,
  input  logic [31:0]        instr_word_i,
  input  logic signed [31:0] read_value_i,
  input  logic               cfg_we_i,
  input  logic [31:0]        cfg_wdata_i,
  output logic [31:0]        start_pc_o,
  output mse_pkg::res_t      res_o
);

  localparam int unsigned RF_AW  = mse_pkg::RF_AW;
  localparam int unsigned MEM_AW = mse_pkg::MEM_AW;
  localparam int unsigned CLR_AW = mse_pkg::CLR_AW;

  // architectural state
  logic [31:0] start_pc_q;
  logic [31:0] pc_q;
  logic        halted_q;

  // sequencing state
  logic [CLR_AW-1:0] clr_cnt_q;
  logic [RF_AW-1:0]  dump_cnt_q;

  // captured item
  logic [31:0] ex_instr_q;
  logic [31:0] ex_pc_q;
  logic [31:0] ex_rdval_q;
  logic        ld_ok_q;

  mse_pkg::res_t out_q;

  // decode of the incoming word, for the register read
  logic             in_is_sys;
  logic [RF_AW-1:0] rf_ra_a;
  logic [RF_AW-1:0] rf_ra_b;
  logic             rf_re_a;

  // register file ports
  logic             rf_we;
  logic [RF_AW-1:0] rf_wa;
  logic [31:0]      rf_wd;
  logic [31:0]      rf_a;
  logic [31:0]      rf_b;

  // data memory ports
  logic              mem_we;
  logic [MEM_AW-1:0] mem_addr;
  logic [31:0]       mem_wd;
  logic [31:0]       mem_rd;

  // execute decode
  logic [5:0]       opcode;
  logic [5:0]       func;
  logic [RF_AW-1:0] rt;
  logic [RF_AW-1:0] rd;
  logic [31:0]      offs;
  logic [31:0]      eff_addr;
  logic             eff_in_range;

  mse_pkg::res_t    ex_res;
  logic             rf_we_ex;
  logic [RF_AW-1:0] rf_wa_ex;
  logic [31:0]      rf_wd_ex;
  logic             mem_we_ex;
  logic             halt_ex;
  logic             is_load;
  logic             is_exit;

  assign in_is_sys = (instr_word_i[31:26] == mse_pkg::OP_SPECIAL) &&
                     (instr_word_i[5:0] == mse_pkg::FN_SYSCALL);

  always_comb begin
    if (cmd_i.capture) begin
      rf_ra_a = in_is_sys ? mse_pkg::REG_V0 : instr_word_i[25:21];
    end else if (cmd_i.dump_out) begin
      rf_ra_a = dump_cnt_q + 1'b1;
    end else begin
      rf_ra_a = mse_pkg::REG_ZERO;
    end
  end

  assign rf_ra_b = in_is_sys ? mse_pkg::REG_A0 : instr_word_i[20:16];
  assign rf_re_a = cmd_i.capture || (cmd_i.commit && is_exit) || cmd_i.dump_out;

  assign opcode       = ex_instr_q[31:26];
  assign func         = ex_instr_q[5:0];
  assign rt           = ex_instr_q[20:16];
  assign rd           = ex_instr_q[15:11];
  assign offs         = {{16{ex_instr_q[15]}}, ex_instr_q[15:0]};
  assign eff_addr     = rf_a + offs;
  assign eff_in_range = (eff_addr[31:2] < mse_pkg::MEM_WORDS_W);

  always_comb begin
    ex_res           = '0;
    ex_res.event_res = mse_pkg::EV_NONE;
    ex_res.instr_pc  = ex_pc_q;
    ex_res.last      = 1'b1;
    rf_we_ex         = 1'b0;
    rf_wa_ex         = rd;
    rf_wd_ex         = rf_a + rf_b;
    mem_we_ex        = 1'b0;
    halt_ex          = 1'b0;
    is_load          = 1'b0;
    is_exit          = 1'b0;
    priority if (halted_q) begin
      ex_res.event_res = mse_pkg::EV_IGNORED;
    end else if (ex_instr_q == 32'd0) begin
      ex_res.event_res = mse_pkg::EV_NONE;
    end else if (opcode == mse_pkg::OP_SPECIAL && func == mse_pkg::FN_ADD) begin
      rf_we_ex = 1'b1;
    end else if (opcode == mse_pkg::OP_SPECIAL && func == mse_pkg::FN_SUB) begin
      rf_we_ex = 1'b1;
      rf_wd_ex = rf_a - rf_b;
    end else if (opcode == mse_pkg::OP_SPECIAL && func == mse_pkg::FN_SYSCALL) begin
      // port a holds v0, port b holds a0
      priority if (rf_a == mse_pkg::SYS_PRINT_INT) begin
        ex_res.event_res = mse_pkg::EV_PRINT_INT;
        ex_res.value     = rf_b;
      end else if (rf_a == mse_pkg::SYS_PRINT_STR) begin
        ex_res.event_res = mse_pkg::EV_PRINT_STR;
        ex_res.value     = rf_b;
      end else if (rf_a == mse_pkg::SYS_READ_INT) begin
        ex_res.event_res = mse_pkg::EV_READ_TAKEN;
        ex_res.value     = ex_rdval_q;
        rf_we_ex         = 1'b1;
        rf_wa_ex         = mse_pkg::REG_V0;
        rf_wd_ex         = ex_rdval_q;
      end else if (rf_a == mse_pkg::SYS_EXIT) begin
        ex_res.event_res = mse_pkg::EV_EXIT;
        ex_res.last      = 1'b0;
        is_exit          = 1'b1;
        halt_ex          = 1'b1;
      end else if (rf_a == mse_pkg::SYS_PRINT_CHAR) begin
        ex_res.event_res = mse_pkg::EV_PRINT_CHAR;
        ex_res.value     = {24'd0, rf_b[7:0]};
      end else begin
        ex_res.event_res = mse_pkg::EV_BAD_SYSCALL;
        ex_res.value     = rf_a;
        halt_ex          = 1'b1;
      end
    end else if (opcode == mse_pkg::OP_LW) begin
      is_load = 1'b1;
    end else if (opcode == mse_pkg::OP_SW) begin
      mem_we_ex = eff_in_range;
    end else begin
      ex_res.event_res = mse_pkg::EV_BAD_INSTR;
      ex_res.value     = ex_instr_q;
      halt_ex          = 1'b1;
    end
  end

  // register file write, register zero never written outside the clear pass
  always_comb begin
    if (cmd_i.clear) begin
      rf_we = 1'b1;
      rf_wa = clr_cnt_q[RF_AW-1:0];
      rf_wd = 32'd0;
    end else if (cmd_i.load_done) begin
      rf_we = (rt != mse_pkg::REG_ZERO);
      rf_wa = rt;
      rf_wd = ld_ok_q ? mem_rd : 32'd0;
    end else begin
      rf_we = cmd_i.commit && rf_we_ex && (rf_wa_ex != mse_pkg::REG_ZERO);
      rf_wa = rf_wa_ex;
      rf_wd = rf_wd_ex;
    end
  end

  always_comb begin
    if (cmd_i.clear) begin
      mem_we   = ({1'b0, clr_cnt_q} < mse_pkg::CLR_MEM_END);
      mem_addr = clr_cnt_q[MEM_AW-1:0];
      mem_wd   = 32'd0;
    end else begin
      mem_we   = cmd_i.commit && mem_we_ex;
      mem_addr = eff_addr[MEM_AW+1:2];
      mem_wd   = rf_b;
    end
  end

  mse_ram #(
    .WIDTH (32),
    .DEPTH (mse_pkg::REG_COUNT)
  ) u_rf_a (
    .clk_i   (clk_i),
    .we_i    (rf_we),
    .waddr_i (rf_wa),
    .wdata_i (rf_wd),
    .re_i    (rf_re_a),
    .raddr_i (rf_ra_a),
    .rdata_o (rf_a)
  );

  mse_ram #(
    .WIDTH (32),
    .DEPTH (mse_pkg::REG_COUNT)
  ) u_rf_b (
    .clk_i   (clk_i),
    .we_i    (rf_we),
    .waddr_i (rf_wa),
    .wdata_i (rf_wd),
    .re_i    (cmd_i.capture),
    .raddr_i (rf_ra_b),
    .rdata_o (rf_b)
  );

  mse_ram #(
    .WIDTH (32),
    .DEPTH (mse_pkg::MEM_WORDS)
  ) u_dmem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_addr),
    .wdata_i (mem_wd),
    .re_i    (cmd_i.mem_rd),
    .raddr_i (mem_addr),
    .rdata_o (mem_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_pc_q <= 32'd0;
      pc_q       <= 32'd0;
      halted_q   <= 1'b0;
      clr_cnt_q  <= '0;
      dump_cnt_q <= '0;
    end else begin
      if (cfg_we_i) begin
        start_pc_q <= cfg_wdata_i;
        pc_q       <= cfg_wdata_i;
      end else if (cmd_i.capture && !halted_q) begin
        pc_q <= pc_q + 32'd4;
      end
      if (cmd_i.commit && halt_ex) begin
        halted_q <= 1'b1;
      end
      if (cmd_i.clear) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
      if (cmd_i.commit && is_exit) begin
        dump_cnt_q <= '0;
      end else if (cmd_i.dump_out) begin
        dump_cnt_q <= dump_cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      ex_instr_q <= instr_word_i;
      ex_pc_q    <= pc_q;
      ex_rdval_q <= read_value_i;
    end
    if (cmd_i.mem_rd) begin
      ld_ok_q <= eff_in_range;
    end
    if (cmd_i.commit) begin
      out_q <= ex_res;
    end else if (cmd_i.load_done) begin
      out_q.event_res <= mse_pkg::EV_NONE;
      out_q.value     <= '0;
      out_q.reg_index <= '0;
      out_q.instr_pc  <= ex_pc_q;
      out_q.last      <= 1'b1;
    end else if (cmd_i.dump_out) begin
      out_q.event_res <= mse_pkg::EV_DUMP;
      out_q.value     <= rf_a;
      out_q.reg_index <= dump_cnt_q;
      out_q.instr_pc  <= ex_pc_q;
      out_q.last      <= (dump_cnt_q == mse_pkg::DUMP_LAST);
    end
  end

  assign status_o.is_load   = is_load;
  assign status_o.is_exit   = is_exit;
  assign status_o.clr_last  = (clr_cnt_q == mse_pkg::CLR_LAST);
  assign status_o.dump_last = (dump_cnt_q == mse_pkg::DUMP_LAST);

  assign start_pc_o = start_pc_q;
  assign res_o      = out_q;

endmodule

// ===== hw/rtl/mips_subset_execute_top.sv =====
`timescale 1ns / 1ps

// Executes a small MIPS32 subset (nop, ADD, SUB, LW, SW, SYSCALL), one instruction
// word per request on instr_i, with results on res_o. After reset the block runs a
// clearing pass over the data memory and register file (the larger of MEM_WORDS and
// 32 words) and takes no request until it finishes; start_pc can be written
// meanwhile. An instruction is then accepted and executed on the registered register
// file read, and LW goes through a further state for the registered data memory
// read. Exit gives the exit result and then the 32 register dump results, one per
// cycle while res_o does not stall. A stall on res_o also holds back each commit.
module mips_subset_execute_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  mse_instr_if.sink          instr_i,
  mse_res_if.source          res_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  mse_pkg::cmd_t    cmd;
  mse_pkg::status_t status;
  mse_pkg::res_t    res;
  logic             cfg_we;
  logic             cfg_sel_start_pc;
  logic [31:0]      start_pc;

  // start_pc is the only register; any address with paddr[2] low selects it
  assign cfg_sel_start_pc = !paddr[2];
  assign cfg_we           = psel && penable && pwrite && pready && cfg_sel_start_pc;
  assign pready           = 1'b1;
  assign prdata           = cfg_sel_start_pc ? start_pc : 32'd0;

  mse_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (instr_i.valid),
    .in_ready_o  (instr_i.ready),
    .out_ready_i (res_o.ready),
    .out_valid_o (res_o.valid),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  mse_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .instr_word_i (instr_i.instr_word),
    .read_value_i (instr_i.read_value),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (pwdata),
    .start_pc_o   (start_pc),
    .res_o        (res)
  );

  assign res_o.event_res = res.event_res;
  assign res_o.value     = res.value;
  assign res_o.reg_index = res.reg_index;
  assign res_o.instr_pc  = res.instr_pc;
  assign res_o.last      = res.last;

  // only the final dump entry closes an exit
  a_dump_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && (res_o.event_res == mse_pkg::EV_DUMP) |->
      (res_o.last == (res_o.reg_index == mse_pkg::DUMP_LAST)))
    else $error("dump last flag does not match register index");

  a_exit_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && (res_o.event_res == mse_pkg::EV_EXIT) |-> !res_o.last)
    else $error("exit result marked last");

  // register zero is cleared at reset and never written
  a_r0_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && (res_o.event_res == mse_pkg::EV_DUMP) &&
      (res_o.reg_index == mse_pkg::REG_ZERO) |-> (res_o.value == 32'sd0))
    else $error("register zero dumped nonzero");

  a_ignored_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && (res_o.event_res == mse_pkg::EV_IGNORED) |->
      (res_o.value == 32'sd0) && res_o.last)
    else $error("ignored request result malformed");

endmodule

// ===== test/tb_mips_subset_execute_top.sv =====
`timescale 1ns / 1ps

module tb_mips_subset_execute_top;

  localparam logic [2:0] ADDR_START_PC = 3'd0;
  localparam int unsigned IDLE_LIMIT   = 5000;
  localparam int unsigned PHASE_ITEMS  = 104;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  mse_instr_if instr_bus ();
  mse_res_if   res_bus ();

  mips_subset_execute_top dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .instr_i (instr_bus),
    .res_o   (res_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // architectural state as the block should hold it
  logic [31:0] cpu_regs [mse_pkg::REG_COUNT];
  logic [31:0] cpu_mem [mse_pkg::MEM_WORDS];
  logic [31:0] cpu_pc;
  logic [31:0] cfg_start_pc;
  logic        cpu_halted;

  mse_pkg::res_t pending_events[$];
  int   error_count   = 0;
  int   src_idle_pct  = 0;
  int   sink_idle_pct = 0;
  int   quiet_cycles  = 0;

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    error_count++;
  endtask

  function automatic logic [31:0] enc_rtype(input logic [4:0] rs, input logic [4:0] rt,
                                            input logic [4:0] rd, input logic [4:0] shamt,
                                            input logic [5:0] func);
    return {mse_pkg::OP_SPECIAL, rs, rt, rd, shamt, func};
  endfunction

  function automatic logic [31:0] enc_mem(input logic [5:0] op, input logic [4:0] rs,
                                          input logic [4:0] rt, input logic [15:0] imm);
    return {op, rs, rt, imm};
  endfunction

  function automatic void push_result(input mse_pkg::event_e ev, input logic [31:0] val,
                                      input logic [4:0] idx, input logic [31:0] pc,
                                      input logic last);
    mse_pkg::res_t r;
    r.event_res = ev;
    r.value     = val;
    r.reg_index = idx;
    r.instr_pc  = pc;
    r.last      = last;
    pending_events.push_back(r);
  endfunction

  function automatic void write_reg(input logic [4:0] idx, input logic [31:0] val);
    if (idx != mse_pkg::REG_ZERO) cpu_regs[idx] = val;
  endfunction

  task automatic execute_instr(input logic [31:0] word, input logic [31:0] rd_val);
    logic [31:0] pc;
    logic [31:0] offs;
    logic [31:0] addr;
    logic [31:0] sel;
    logic [31:0] a0;
    logic [5:0]  opcode;
    logic [5:0]  func;
    logic [4:0]  rs;
    logic [4:0]  rt;
    logic [4:0]  rd;
    pc = cpu_pc;
    if (cpu_halted) begin
      push_result(mse_pkg::EV_IGNORED, 32'd0, 5'd0, pc, 1'b1);
      return;
    end
    cpu_pc = pc + 32'd4;
    opcode = word[31:26];
    rs     = word[25:21];
    rt     = word[20:16];
    rd     = word[15:11];
    func   = word[5:0];
    offs   = {{16{word[15]}}, word[15:0]};
    addr   = cpu_regs[rs] + offs;
    if (word == 32'd0) begin
      push_result(mse_pkg::EV_NONE, 32'd0, 5'd0, pc, 1'b1);
    end else if (opcode == mse_pkg::OP_SPECIAL && func == mse_pkg::FN_ADD) begin
      write_reg(rd, cpu_regs[rs] + cpu_regs[rt]);
      push_result(mse_pkg::EV_NONE, 32'd0, 5'd0, pc, 1'b1);
    end else if (opcode == mse_pkg::OP_SPECIAL && func == mse_pkg::FN_SUB) begin
      write_reg(rd, cpu_regs[rs] - cpu_regs[rt]);
      push_result(mse_pkg::EV_NONE, 32'd0, 5'd0, pc, 1'b1);
    end else if (opcode == mse_pkg::OP_SPECIAL && func == mse_pkg::FN_SYSCALL) begin
      sel = cpu_regs[mse_pkg::REG_V0];
      a0  = cpu_regs[mse_pkg::REG_A0];
      if (sel == mse_pkg::SYS_PRINT_INT) begin
        push_result(mse_pkg::EV_PRINT_INT, a0, 5'd0, pc, 1'b1);
      end else if (sel == mse_pkg::SYS_PRINT_STR) begin
        push_result(mse_pkg::EV_PRINT_STR, a0, 5'd0, pc, 1'b1);
      end else if (sel == mse_pkg::SYS_READ_INT) begin
        write_reg(mse_pkg::REG_V0, rd_val);
        push_result(mse_pkg::EV_READ_TAKEN, rd_val, 5'd0, pc, 1'b1);
      end else if (sel == mse_pkg::SYS_EXIT) begin
        push_result(mse_pkg::EV_EXIT, 32'd0, 5'd0, pc, 1'b0);
        for (int i = 0; i < mse_pkg::REG_COUNT; i++) begin
          push_result(mse_pkg::EV_DUMP, cpu_regs[i], 5'(i), pc,
                      i == mse_pkg::REG_COUNT - 1);
        end
        cpu_halted = 1'b1;
      end else if (sel == mse_pkg::SYS_PRINT_CHAR) begin
        push_result(mse_pkg::EV_PRINT_CHAR, {24'd0, a0[7:0]}, 5'd0, pc, 1'b1);
      end else begin
        push_result(mse_pkg::EV_BAD_SYSCALL, sel, 5'd0, pc, 1'b1);
        cpu_halted = 1'b1;
      end
    end else if (opcode == mse_pkg::OP_LW) begin
      write_reg(rt, (addr[31:2] < mse_pkg::MEM_WORDS_W) ?
                    cpu_mem[addr[mse_pkg::MEM_AW+1:2]] : 32'd0);
      push_result(mse_pkg::EV_NONE, 32'd0, 5'd0, pc, 1'b1);
    end else if (opcode == mse_pkg::OP_SW) begin
      if (addr[31:2] < mse_pkg::MEM_WORDS_W) cpu_mem[addr[mse_pkg::MEM_AW+1:2]] = cpu_regs[rt];
      push_result(mse_pkg::EV_NONE, 32'd0, 5'd0, pc, 1'b1);
    end else begin
      push_result(mse_pkg::EV_BAD_INSTR, word, 5'd0, pc, 1'b1);
      cpu_halted = 1'b1;
    end
  endtask

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_instr(input logic [31:0] word, input logic [31:0] rd_val);
    if ($urandom_range(0, 99) < src_idle_pct) begin
      instr_bus.valid <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(0, 99) < src_idle_pct);
    end
    instr_bus.valid      <= 1'b1;
    instr_bus.instr_word <= word;
    instr_bus.read_value <= rd_val;
    do @(posedge clk_i); while (!instr_bus.ready);
    execute_instr(word, rd_val);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    instr_bus.valid <= 1'b0;
    while (pending_events.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic set_start_pc(input logic [31:0] val);
    logic [31:0] readback;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_START_PC;
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    cfg_start_pc = val;
    cpu_pc       = val;
    // read back through a second transfer
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    readback = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (readback !== cfg_start_pc)
      report_mismatch($sformatf("start_pc read %h, wrote %h", readback, cfg_start_pc));
  endtask

  // instructions that never halt: nop, ADD, SUB, LW, SW with random fields
  function automatic logic [31:0] rand_quiet_instr();
    logic [15:0] imm;
    int unsigned kind;
    kind = $urandom_range(0, 9);
    imm  = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4095));
    case (kind)
      0: return 32'd0;
      1, 2: return enc_rtype(5'($urandom), 5'($urandom), 5'($urandom), 5'($urandom),
                             mse_pkg::FN_ADD);
      3, 4: return enc_rtype(5'($urandom), 5'($urandom), 5'($urandom), 5'($urandom),
                             mse_pkg::FN_SUB);
      5, 6, 7: return enc_mem(mse_pkg::OP_LW, 5'($urandom), 5'($urandom), imm);
      default: return enc_mem(mse_pkg::OP_SW, 5'($urandom), 5'($urandom), imm);
    endcase
  endfunction

  task automatic test_directed_ops();
    send_instr(32'd0, 32'h8000_0000);
    send_instr(enc_rtype(31, 31, 31, 31, mse_pkg::FN_ADD), 32'h7FFF_FFFF);
    send_instr(enc_rtype(0, 0, 0, 0, mse_pkg::FN_ADD), 32'hFFFF_FFFF);
    send_instr(enc_rtype(5, 6, 7, 0, mse_pkg::FN_SUB), 32'd0);
    send_instr(enc_rtype(31, 0, 1, 31, mse_pkg::FN_SUB), 32'd1);
    send_instr(enc_mem(mse_pkg::OP_SW, 0, 0, 16'h0000), 32'd0);
    send_instr(enc_mem(mse_pkg::OP_LW, 0, 31, 16'h0000), 32'd0);
    send_instr(enc_mem(mse_pkg::OP_SW, 31, 31, 16'h7FFF), 32'd0);
    send_instr(enc_mem(mse_pkg::OP_LW, 31, 1, 16'h7FFF), 32'd0);
    send_instr(enc_mem(mse_pkg::OP_LW, 0, 2, 16'h8000), 32'd0);
    send_instr(enc_mem(mse_pkg::OP_SW, 0, 3, 16'hFFFC), 32'd0);
    // last word in range, then the first one past it
    send_instr(enc_mem(mse_pkg::OP_SW, 0, 4, 16'h0FFC), 32'd0);
    send_instr(enc_mem(mse_pkg::OP_LW, 0, 5, 16'h0FFC), 32'd0);
    send_instr(enc_mem(mse_pkg::OP_LW, 0, 6, 16'h1000), 32'd0);
    // unaligned address, then a use of the loaded register right away
    send_instr(enc_mem(mse_pkg::OP_LW, 0, 8, 16'h0003), 32'd0);
    send_instr(enc_rtype(8, 8, 9, 0, mse_pkg::FN_ADD), 32'd0);
    send_instr(enc_rtype(9, 8, 0, 0, mse_pkg::FN_SUB), 32'd0);
    send_instr(enc_mem(mse_pkg::OP_SW, 9, 8, 16'h0004), 32'd0);
    send_instr(enc_mem(mse_pkg::OP_LW, 9, 10, 16'h0004), 32'd0);
  endtask

  task automatic test_random_stream(input int unsigned count);
    repeat (count) send_instr(rand_quiet_instr(), $urandom);
  endtask

  // registers only leave zero through read int, which needs v0 == 5, so any
  // syscall here halts; a halt is final since reset is applied only once
  task automatic test_halt_and_ignore();
    logic [31:0] word;
    wait_drained();
    set_start_pc($urandom & 32'hFFFF_FFFC);
    test_random_stream(8);
    if ($urandom_range(0, 1) == 0) begin
      word = enc_rtype(5'($urandom), 5'($urandom), 5'($urandom), 5'($urandom),
                       mse_pkg::FN_SYSCALL);
    end else begin
      do word = $urandom;
      while (word[31:26] inside {mse_pkg::OP_SPECIAL, mse_pkg::OP_LW, mse_pkg::OP_SW});
    end
    send_instr(word, $urandom);
    send_instr(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_instr(32'd0, 32'd0);
    repeat (12) send_instr($urandom, $urandom);
    wait_drained();
    // pc reload while halted
    set_start_pc(32'hFFFF_FFFC);
    repeat (6) send_instr($urandom, $urandom);
  endtask

  always @(negedge clk_i) begin
    res_bus.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
  end

  always @(posedge clk_i) begin : check_results
    mse_pkg::res_t want;
    if (rst_ni && res_bus.valid && res_bus.ready) begin
      if (pending_events.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected: event %0d pc %h",
                                  res_bus.event_res, res_bus.instr_pc));
      end else begin
        want = pending_events.pop_front();
        if (res_bus.event_res !== want.event_res)
          report_mismatch($sformatf("event_res %0d, expected %0d (pc %h)",
                                    res_bus.event_res, want.event_res, want.instr_pc));
        if (res_bus.value !== want.value)
          report_mismatch($sformatf("value %h, expected %h (pc %h)",
                                    res_bus.value, want.value, want.instr_pc));
        if (res_bus.reg_index !== want.reg_index)
          report_mismatch($sformatf("reg_index %0d, expected %0d (pc %h)",
                                    res_bus.reg_index, want.reg_index, want.instr_pc));
        if (res_bus.instr_pc !== want.instr_pc)
          report_mismatch($sformatf("instr_pc %h, expected %h",
                                    res_bus.instr_pc, want.instr_pc));
        if (res_bus.last !== want.last)
          report_mismatch($sformatf("last %b, expected %b (pc %h)",
                                    res_bus.last, want.last, want.instr_pc));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((instr_bus.valid && instr_bus.ready) || (res_bus.valid && res_bus.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    rst_ni               = 1'b0;
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = '0;
    pwdata               = '0;
    instr_bus.valid      = 1'b0;
    instr_bus.instr_word = '0;
    instr_bus.read_value = '0;
    res_bus.ready        = 1'b0;
    for (int i = 0; i < mse_pkg::REG_COUNT; i++) cpu_regs[i] = '0;
    for (int i = 0; i < mse_pkg::MEM_WORDS; i++) cpu_mem[i] = '0;
    cfg_start_pc = '0;
    cpu_pc       = '0;
    cpu_halted   = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    src_idle_pct  = 13;
    sink_idle_pct = 47;
    // written during the clearing pass
    set_start_pc(32'h0000_0000);
    test_directed_ops();
    wait_drained();
    set_start_pc($urandom & 32'hFFFF_FFFC);
    test_random_stream(PHASE_ITEMS);

    wait_drained();
    src_idle_pct  = 47;
    sink_idle_pct = 13;
    // pc wraps past zero during this stream
    set_start_pc(32'hFFFF_FF00);
    test_random_stream(PHASE_ITEMS);

    wait_drained();
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    set_start_pc(32'hFFFF_FFFF);
    test_random_stream(PHASE_ITEMS);

    test_halt_and_ignore();

    wait_drained();
    repeat (40) @(posedge clk_i);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
